// ===== design/bdl_pkg.sv =====
// Shared constants, types and helper functions of the binaural delay, lowpass and reverb block.
package bdl_pkg;

  localparam int SAMPLE_W     = 17;
  localparam int PCM_W        = 16;
  localparam int STATE_W      = 25;
  localparam int Q_FRAC       = 15;

  localparam int DELAY_DEPTH  = 128;
  localparam int MAX_DELAY    = 64;
  localparam int REVERB_DEPTH = 1024;
  localparam int DA_W         = $clog2(DELAY_DEPTH);
  localparam int RA_W         = $clog2(REVERB_DEPTH);
  localparam int RL_W         = $clog2(REVERB_DEPTH + 1);

  localparam int DELAY_W      = 7;
  localparam int COEF_W       = 16;
  localparam int LEVEL_W      = 15;
  localparam int LEN_W        = 10;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int EAR_LAT      = 5;

  localparam logic [COEF_W-1:0]  COEF_ONE     = COEF_W'(1 << Q_FRAC);
  localparam logic [COEF_W-1:0]  COEF_RESET   = COEF_W'(19412);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = LEVEL_W'(4915);
  localparam logic [LEN_W-1:0]   LENGTH_RESET = LEN_W'(512);

  localparam int PCM_MAX_I = (1 << (PCM_W - 1)) - 1;
  localparam logic signed [PCM_W+1:0] PCM_MAX = (PCM_W+2)'(PCM_MAX_I);
  localparam logic signed [PCM_W+1:0] PCM_MIN = (PCM_W+2)'(-PCM_MAX_I - 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EFFECT_ENABLE,
    REG_REVERB_ENABLE,
    REG_LEFT_DELAY,
    REG_RIGHT_DELAY,
    REG_LOWPASS_FEEDBACK,
    REG_REVERB_GAIN,
    REG_REVERB_LENGTH
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_MONO,
    ST_TAP,
    ST_EAR,
    ST_AVG,
    ST_MUL,
    ST_ACC,
    ST_MIX,
    ST_OUT
  } seq_state_t;

  function automatic logic signed [PCM_W-1:0] sat_pcm(input logic signed [PCM_W+1:0] v);
    if (v > PCM_MAX) return PCM_MAX[PCM_W-1:0];
    if (v < PCM_MIN) return PCM_MIN[PCM_W-1:0];
    return v[PCM_W-1:0];
  endfunction

endpackage

// ===== design/bdl_if.sv =====
// Request channel interfaces: input frames, result frames and configuration writes.
interface bdl_in_if import bdl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

interface bdl_out_if import bdl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface bdl_cfg_if import bdl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== design/bdl_delay_mem.sv =====
// Interaural delay ring: one write port, two registered read ports, per-entry valid bits.
module bdl_delay_mem import bdl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [DA_W-1:0]         wr_addr,
  input  logic signed [PCM_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [DA_W-1:0]         rd_addr_l,
  input  logic [DA_W-1:0]         rd_addr_r,
  output logic signed [PCM_W-1:0] rd_data_l,
  output logic signed [PCM_W-1:0] rd_data_r
);

  logic signed [PCM_W-1:0] mem [DELAY_DEPTH];
  logic [DELAY_DEPTH-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_l <= vld[rd_addr_l] ? mem[rd_addr_l] : '0;
      rd_data_r <= vld[rd_addr_r] ? mem[rd_addr_r] : '0;
    end
  end

endmodule

// ===== design/bdl_reverb_mem.sv =====
// Comb reverb line: single-port memory with a clearing sweep after reset.
module bdl_reverb_mem import bdl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic                    wr_en,
  input  logic [RA_W-1:0]         addr,
  input  logic signed [PCM_W-1:0] wr_data,
  output logic signed [PCM_W-1:0] rd_data,
  output logic                    busy
);

  logic signed [PCM_W-1:0] mem [REVERB_DEPTH];
  logic                    clearing;
  logic [RA_W-1:0]         clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + RA_W'(1);
      if (clr_addr == RA_W'(REVERB_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign busy = clearing;

endmodule

// ===== design/bdl_ear.sv =====
// One ear: one-pole lowpass with Q15 coefficients, then 4/5 output scaling and clamping.
module bdl_ear import bdl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic signed [PCM_W-1:0] tap,
  input  logic [COEF_W-1:0]       fb_coef,
  output logic                    done,
  output logic signed [PCM_W-1:0] value
);

  localparam int FF_PROD_W   = COEF_W + 2 + PCM_W;
  localparam int FB_PROD_W   = COEF_W + 1 + STATE_W;
  localparam int ACC_W       = FB_PROD_W + 1;
  localparam int LP_FRAC     = 8;
  localparam int SCALE_PRE   = 6;
  localparam int SCALE_ROUND = 160;
  localparam int SCALE_SHIFT = 21;
  localparam int X_W         = STATE_W - SCALE_PRE;
  localparam int RECIP_W     = 19;
  localparam int QP_W        = X_W + RECIP_W;
  localparam int QV_W        = QP_W - SCALE_SHIFT;
  localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(419431);
  localparam logic signed [ACC_W-1:0] LP_ROUND = ACC_W'(1 << (Q_FRAC - 1));

  logic [EAR_LAT-1:0]           pipe;
  logic [COEF_W:0]              ff_coef;
  logic signed [FF_PROD_W-1:0]  ff_prod;
  logic signed [FB_PROD_W-1:0]  fb_prod;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      lp_full;
  logic signed [STATE_W-1:0]    lp_state;
  logic [STATE_W-1:0]           mag;
  logic [STATE_W-1:0]           ysum;
  logic [X_W-1:0]               x;
  logic                         neg1;
  logic                         neg2;
  logic [QP_W-1:0]              qprod;
  logic [QV_W-1:0]              qv;
  logic signed [PCM_W+1:0]      sval;

  assign ff_coef = (COEF_W+1)'(COEF_ONE) - (COEF_W+1)'(fb_coef);

  always_comb begin
    acc     = (ACC_W'(ff_prod) <<< LP_FRAC) + ACC_W'(fb_prod) + LP_ROUND;
    lp_full = acc >>> Q_FRAC;
    mag     = lp_state[STATE_W-1] ? STATE_W'(-lp_state) : STATE_W'(lp_state);
    ysum    = mag + STATE_W'(SCALE_ROUND);
    qv      = qprod[QP_W-1:SCALE_SHIFT];
    sval    = neg2 ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe     <= '0;
      lp_state <= '0;
    end else begin
      pipe <= {pipe[EAR_LAT-2:0], step};
      if (pipe[0]) begin
        lp_state <= lp_full[STATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ff_prod <= $signed({1'b0, ff_coef}) * tap;
      fb_prod <= $signed({1'b0, fb_coef}) * lp_state;
    end
    if (pipe[1]) begin
      x    <= ysum[STATE_W-1:SCALE_PRE];
      neg1 <= lp_state[STATE_W-1];
    end
    if (pipe[2]) begin
      qprod <= x * SCALE_RECIP;
      neg2  <= neg1;
    end
    if (pipe[3]) begin
      value <= sat_pcm(sval);
    end
  end

  assign done = pipe[EAR_LAT-1];

endmodule

// ===== design/binaural_delay_lowpass_reverb.sv =====
// Top level: frame sequencer, configuration registers, delay ring, ear filters and comb reverb.
// Processing: a bypassed frame goes straight to the output register; a processed frame runs the
// five-stage ear multiply chain, and with the reverb on also the reverb step.
// Throughput: one frame at a time; a new request is taken only after the previous result
// is loaded into the output register; a stale reverb position adds a remainder pass.
// Reset: synchronous rst clears control state, then the reverb line is swept to zero, during
// which no frame request is taken; configuration writes are always taken.
module binaural_delay_lowpass_reverb import bdl_pkg::*; (
  input logic       clk,
  input logic       rst,
  bdl_in_if.sink    sample,
  bdl_out_if.source result,
  bdl_cfg_if.sink   cfg
);

  localparam int REM_W    = RA_W + 1;
  localparam int CNT_W    = $clog2(RA_W);
  localparam int PROD_W   = 2 * PCM_W;
  localparam int TAP_SHIFT = 2;
  localparam logic [PROD_W-1:0] INJ_BIAS = PROD_W'((1 << Q_FRAC) - 1);

  logic                 effect_enable;
  logic                 reverb_enable;
  logic [DELAY_W-1:0]   left_delay;
  logic [DELAY_W-1:0]   right_delay;
  logic [COEF_W-1:0]    lowpass_feedback;
  logic [LEVEL_W-1:0]   reverb_gain;
  logic [LEN_W-1:0]     reverb_length;

  seq_state_t           state;
  seq_state_t           state_next;
  logic [DA_W-1:0]      delay_wpos;
  logic [RA_W-1:0]      rv_pos;

  logic signed [SAMPLE_W-1:0] li;
  logic signed [SAMPLE_W-1:0] ri;
  logic signed [SAMPLE_W-1:0] res_l;
  logic signed [SAMPLE_W-1:0] res_r;
  logic signed [PCM_W-1:0]    mono;
  logic signed [PCM_W-1:0]    mono_r;
  logic                       zero_l;
  logic                       zero_r;
  logic [REM_W-1:0]           rem_acc;
  logic [REM_W-1:0]           rem_trial;
  logic [REM_W-1:0]           rem_next;
  logic [RA_W-1:0]            rem_div;
  logic [CNT_W-1:0]           rem_cnt;
  logic                       rem_last;
  logic signed [PCM_W-1:0]    avg_r;
  logic signed [PROD_W-1:0]   inj_prod;
  logic signed [PROD_W-1:0]   inj_sum;
  logic signed [PCM_W-1:0]    rv_sum_sat;
  logic signed [PCM_W-1:0]    rv_new;
  logic signed [PCM_W-1:0]    rv_tap;

  logic [RL_W-1:0]      len;
  logic                 pos_stale;
  logic [RA_W-1:0]      rv_pos_inc;
  logic [DELAY_W-1:0]   dl_l;
  logic [DELAY_W-1:0]   dl_r;
  logic [COEF_W-1:0]    fb_sat;

  logic                    dmem_wr_en;
  logic                    dmem_rd_en;
  logic signed [PCM_W-1:0] dmem_rd_l;
  logic signed [PCM_W-1:0] dmem_rd_r;
  logic                    rv_rd_en;
  logic                    rv_wr_en;
  logic signed [PCM_W-1:0] rv_rd_data;
  logic                    rv_busy;
  logic                    ear_step;
  logic                    ear_done_l;
  logic                    ear_done_r;
  logic signed [PCM_W-1:0] ear_val_l;
  logic signed [PCM_W-1:0] ear_val_r;
  logic signed [PCM_W-1:0] tap_l;
  logic signed [PCM_W-1:0] tap_r;
  logic                    out_load;

  function automatic logic signed [PCM_W-1:0] half_toward_zero(
    input logic signed [PCM_W:0] s
  );
    logic [PCM_W:0] adj;
    adj = s + {{PCM_W{1'b0}}, s[PCM_W]};
    return adj[PCM_W:1];
  endfunction

  function automatic logic [DA_W-1:0] back_addr(input logic [DA_W-1:0] w,
                                                input logic [DELAY_W-1:0] d);
    logic [DA_W:0] we;
    logic [DA_W:0] de;
    we = (DA_W+1)'(w);
    de = (DA_W+1)'(d);
    if (we >= de) return DA_W'(we - de);
    return DA_W'(we + (DA_W+1)'(DELAY_DEPTH) - de);
  endfunction

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_enable    <= 1'b0;
      reverb_enable    <= 1'b0;
      left_delay       <= '0;
      right_delay      <= '0;
      lowpass_feedback <= COEF_RESET;
      reverb_gain      <= LEVEL_RESET;
      reverb_length    <= LENGTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_EFFECT_ENABLE:    effect_enable    <= cfg.data[0];
        REG_REVERB_ENABLE:    reverb_enable    <= cfg.data[0];
        REG_LEFT_DELAY:       left_delay       <= cfg.data[DELAY_W-1:0];
        REG_RIGHT_DELAY:      right_delay      <= cfg.data[DELAY_W-1:0];
        REG_LOWPASS_FEEDBACK: lowpass_feedback <= cfg.data[COEF_W-1:0];
        REG_REVERB_GAIN:      reverb_gain      <= cfg.data[LEVEL_W-1:0];
        REG_REVERB_LENGTH:    reverb_length    <= cfg.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Derived operating values.
  always_comb begin
    len = (reverb_length == '0) ? RL_W'(1) : RL_W'(reverb_length);
    if (len > RL_W'(REVERB_DEPTH)) begin
      len = RL_W'(REVERB_DEPTH);
    end
    pos_stale  = RL_W'(rv_pos) >= len;
    rv_pos_inc = (RL_W'(rv_pos) + RL_W'(1) == len) ? '0 : rv_pos + RA_W'(1);
    dl_l       = (left_delay > DELAY_W'(MAX_DELAY)) ? DELAY_W'(MAX_DELAY) : left_delay;
    dl_r       = (right_delay > DELAY_W'(MAX_DELAY)) ? DELAY_W'(MAX_DELAY) : right_delay;
    fb_sat     = (lowpass_feedback > COEF_ONE) ? COEF_ONE : lowpass_feedback;
    mono       = half_toward_zero((PCM_W+1)'(sat_pcm((PCM_W+2)'(li)))
                                + (PCM_W+1)'(sat_pcm((PCM_W+2)'(ri))));
    rem_trial  = {rem_acc[REM_W-2:0], rem_div[RA_W-1]};
    rem_next   = (rem_trial >= REM_W'(len)) ? rem_trial - REM_W'(len) : rem_trial;
    rem_last   = rem_cnt == CNT_W'(RA_W - 1);
    tap_l      = zero_l ? mono_r : dmem_rd_l;
    tap_r      = zero_r ? mono_r : dmem_rd_r;
    inj_sum    = inj_prod + (inj_prod[PROD_W-1] ? $signed(INJ_BIAS) : '0);
    rv_sum_sat = sat_pcm((PCM_W+2)'(rv_rd_data)
                       + (PCM_W+2)'($signed(inj_sum[Q_FRAC+PCM_W-1:Q_FRAC])));
    rv_tap     = rv_new >>> TAP_SHIFT;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      delay_wpos <= '0;
      rv_pos     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MONO) begin
        delay_wpos <= (delay_wpos == DA_W'(DELAY_DEPTH - 1)) ? '0 : delay_wpos + DA_W'(1);
      end
      if (state == ST_MOD && rem_last) begin
        rv_pos <= rem_next[RA_W-1:0];
      end else if (state == ST_ACC) begin
        rv_pos <= rv_pos_inc;
      end
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    dmem_wr_en   = 1'b0;
    dmem_rd_en   = 1'b0;
    rv_rd_en     = 1'b0;
    rv_wr_en     = 1'b0;
    ear_step     = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = !rv_busy;
        if (sample.valid && !rv_busy) begin
          if (!effect_enable) begin
            state_next = ST_OUT;
          end else if (reverb_enable && pos_stale) begin
            state_next = ST_MOD;
          end else begin
            state_next = ST_MONO;
          end
        end
      end
      ST_MOD: begin
        if (rem_last) begin
          state_next = ST_MONO;
        end
      end
      ST_MONO: begin
        dmem_wr_en = 1'b1;
        dmem_rd_en = 1'b1;
        rv_rd_en   = reverb_enable;
        state_next = ST_TAP;
      end
      ST_TAP: begin
        ear_step   = 1'b1;
        state_next = ST_EAR;
      end
      ST_EAR: begin
        if (ear_done_l) begin
          state_next = reverb_enable ? ST_AVG : ST_OUT;
        end
      end
      ST_AVG: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        rv_wr_en   = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: state_next = ST_OUT;
      ST_OUT: begin
        out_load = !result.valid || result.ready;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      li      <= sample.left_in;
      ri      <= sample.right_in;
      res_l   <= sample.left_in;
      res_r   <= sample.right_in;
      rem_acc <= '0;
      rem_div <= rv_pos;
      rem_cnt <= '0;
    end
    if (state == ST_MOD) begin
      rem_acc <= rem_next;
      rem_div <= rem_div << 1;
      rem_cnt <= rem_cnt + CNT_W'(1);
    end
    if (state == ST_MONO) begin
      mono_r <= mono;
      zero_l <= dl_l == '0;
      zero_r <= dl_r == '0;
    end
    if (state == ST_EAR && ear_done_l) begin
      res_l <= SAMPLE_W'(ear_val_l);
      res_r <= SAMPLE_W'(ear_val_r);
    end
    if (state == ST_AVG) begin
      avg_r <= half_toward_zero((PCM_W+1)'(ear_val_l) + (PCM_W+1)'(ear_val_r));
    end
    if (state == ST_MUL) begin
      inj_prod <= avg_r * $signed({1'b0, reverb_gain});
    end
    if (state == ST_ACC) begin
      rv_new <= rv_sum_sat;
    end
    if (state == ST_MIX) begin
      res_l <= SAMPLE_W'(sat_pcm((PCM_W+2)'(ear_val_l) + (PCM_W+2)'(rv_tap)));
      res_r <= SAMPLE_W'(sat_pcm((PCM_W+2)'(ear_val_r) + (PCM_W+2)'(rv_tap)));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.left_out  <= res_l;
      result.right_out <= res_r;
    end
  end

  bdl_delay_mem u_delay_mem (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (dmem_wr_en),
    .wr_addr   (delay_wpos),
    .wr_data   (mono),
    .rd_en     (dmem_rd_en),
    .rd_addr_l (back_addr(delay_wpos, dl_l)),
    .rd_addr_r (back_addr(delay_wpos, dl_r)),
    .rd_data_l (dmem_rd_l),
    .rd_data_r (dmem_rd_r)
  );

  bdl_reverb_mem u_reverb_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rv_rd_en),
    .wr_en   (rv_wr_en),
    .addr    (rv_pos),
    .wr_data (rv_sum_sat),
    .rd_data (rv_rd_data),
    .busy    (rv_busy)
  );

  bdl_ear u_ear_l (
    .clk     (clk),
    .rst     (rst),
    .step    (ear_step),
    .tap     (tap_l),
    .fb_coef (fb_sat),
    .done    (ear_done_l),
    .value   (ear_val_l)
  );

  bdl_ear u_ear_r (
    .clk     (clk),
    .rst     (rst),
    .step    (ear_step),
    .tap     (tap_r),
    .fb_coef (fb_sat),
    .done    (ear_done_r),
    .value   (ear_val_r)
  );

  // Both ear filters finish together after they are started.
  a_ear_latency: assert property (@(posedge clk) disable iff (rst)
    ear_step |-> ##(EAR_LAT) (ear_done_l && ear_done_r))
    else $error("Ear filters did not finish together at the expected latency.");

  // A bypassed frame must leave the ring and reverb positions untouched.
  a_bypass_holds_state: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready && !effect_enable) |=>
      ($stable(delay_wpos) && $stable(rv_pos)))
    else $error("Bypassed frame moved the delay or reverb position.");

  // A finished frame waits while the output register is still held by the consumer.
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && result.valid && !result.ready) |=> (state == ST_OUT))
    else $error("Result overwritten while the previous one was still waiting.");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the binaural delay, lowpass and comb reverb block.
module tb_top;
  import bdl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = CFG_ADDR_W'(7);
  localparam int QUIET_LIMIT = 8000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_FRAMES = 1500;
  localparam int CALM_FRAMES = 150;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic clk;
  logic rst;

  bdl_in_if  frame_in ();
  bdl_out_if frame_out ();
  bdl_cfg_if cfg_bus ();

  binaural_delay_lowpass_reverb dut (
    .clk    (clk),
    .rst    (rst),
    .sample (frame_in),
    .result (frame_out),
    .cfg    (cfg_bus)
  );

  frame_t pending_frames[$];
  frame_t expected_frames[$];
  bit     frame_held;
  bit     idle_on;
  bit     calm;
  int     send_gap;
  int     stall_left;
  int     quiet_cycles;
  int     err_count;

  int fx_on;
  int reverb_on;
  int left_lag;
  int right_lag;
  int fb_coef;
  int comb_level;
  int comb_len;

  logic signed [PCM_W-1:0] mono_ring [DELAY_DEPTH];
  int                      ring_wr;
  int                      lp_left_acc;
  int                      lp_right_acc;
  logic signed [PCM_W-1:0] comb_line [REVERB_DEPTH];
  int                      comb_pos;

  function automatic int clamp16(input longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return int'(v);
  endfunction

  function automatic int lowpass_step(input int state, input int d);
    longint a;
    longint b;
    longint acc;
    a = (fb_coef > 32768) ? 32768 : fb_coef;
    b = 32768 - a;
    acc = b * d * 256 + a * state + 16384;
    return int'(acc >>> 15);
  endfunction

  function automatic int ear_scale(input int state);
    int m;
    int q;
    m = (state < 0) ? -state : state;
    q = (m + 160) / 320;
    return clamp16((state < 0) ? -q : q);
  endfunction

  function automatic frame_t predict_frame(input logic signed [SAMPLE_W-1:0] l_in,
                                           input logic signed [SAMPLE_W-1:0] r_in);
    frame_t o;
    int     li;
    int     ri;
    int     mono;
    int     w;
    int     dl;
    int     dr;
    int     fl;
    int     fr;
    int     len;
    int     p;
    int     cv;
    int     tap;
    longint avg;
    longint inj;
    li = l_in;
    ri = r_in;
    if (fx_on == 0) begin
      o.left = l_in;
      o.right = r_in;
      return o;
    end
    mono = (clamp16(li) + clamp16(ri)) / 2;
    w = ring_wr;
    mono_ring[w] = mono[PCM_W-1:0];
    ring_wr = (w + 1) % DELAY_DEPTH;
    dl = (left_lag > MAX_DELAY) ? MAX_DELAY : left_lag;
    dr = (right_lag > MAX_DELAY) ? MAX_DELAY : right_lag;
    lp_left_acc = lowpass_step(lp_left_acc, mono_ring[(w + DELAY_DEPTH - dl) % DELAY_DEPTH]);
    lp_right_acc = lowpass_step(lp_right_acc, mono_ring[(w + DELAY_DEPTH - dr) % DELAY_DEPTH]);
    fl = ear_scale(lp_left_acc);
    fr = ear_scale(lp_right_acc);
    if (reverb_on != 0) begin
      len = (comb_len == 0) ? 1 : comb_len;
      if (len > REVERB_DEPTH) len = REVERB_DEPTH;
      p = comb_pos % len;
      avg = (longint'(fl) + fr) / 2;
      inj = (avg * comb_level) / 32768;
      cv = comb_line[p];
      cv = clamp16(cv + inj);
      comb_line[p] = cv[PCM_W-1:0];
      tap = cv >>> 2;
      fl = clamp16(fl + tap);
      fr = clamp16(fr + tap);
      comb_pos = (p + 1) % len;
    end
    o.left = fl[SAMPLE_W-1:0];
    o.right = fr[SAMPLE_W-1:0];
    return o;
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < 200) $display("%0t ERROR %s", $realtime, msg);
    err_count++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_EFFECT_ENABLE:    fx_on = data & 16'h1;
      REG_REVERB_ENABLE:    reverb_on = data & 16'h1;
      REG_LEFT_DELAY:       left_lag = data & 16'h7F;
      REG_RIGHT_DELAY:      right_lag = data & 16'h7F;
      REG_LOWPASS_FEEDBACK: fb_coef = data;
      REG_REVERB_GAIN:      comb_level = data & 16'h7FFF;
      REG_REVERB_LENGTH:    comb_len = data & 16'h3FF;
      default: ;
    endcase
  endtask

  task automatic set_fx(input int en, input int rv, input int ld, input int rd,
                        input int fb, input int lvl, input int len);
    write_reg(REG_EFFECT_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_REVERB_ENABLE, CFG_DATA_W'(rv));
    write_reg(REG_LEFT_DELAY, CFG_DATA_W'(ld));
    write_reg(REG_RIGHT_DELAY, CFG_DATA_W'(rd));
    write_reg(REG_LOWPASS_FEEDBACK, CFG_DATA_W'(fb));
    write_reg(REG_REVERB_GAIN, CFG_DATA_W'(lvl));
    write_reg(REG_REVERB_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic push_frame(input int l, input int r);
    frame_t f;
    f.left = l[SAMPLE_W-1:0];
    f.right = r[SAMPLE_W-1:0];
    pending_frames.push_back(f);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_frames.size() != 0 || frame_held || expected_frames.size() != 0);
  endtask

  function automatic int edgy(input int lo, input int hi, input int top);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2: return top;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? -65536 : 65534;
      1, 2, 3, 4, 5: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 131070)) - 65536;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : drive_frames
    frame_t frame;
    if (rst) begin
      frame_in.valid <= 1'b0;
    end else begin
      if (frame_in.valid && frame_in.ready) begin
        expected_frames.push_back(predict_frame(frame_in.left_in, frame_in.right_in));
        frame_held = 1'b0;
      end
      if (!frame_in.valid || frame_in.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          frame_in.valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          frame = pending_frames.pop_front();
          frame_held = 1'b1;
          frame_in.valid <= 1'b1;
          frame_in.left_in <= frame.left;
          frame_in.right_in <= frame.right;
          if (idle_on && !calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          frame_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    frame_t want;
    if (rst) begin
      frame_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (frame_out.valid && frame_out.ready) begin
        if (expected_frames.size() == 0) begin
          flag_error($sformatf("result %0d/%0d arrived with none expected",
                               frame_out.left_out, frame_out.right_out));
        end else begin
          want = expected_frames.pop_front();
          if (frame_out.left_out !== want.left)
            flag_error($sformatf("left_out expected %0d got %0d", want.left, frame_out.left_out));
          if (frame_out.right_out !== want.right)
            flag_error($sformatf("right_out expected %0d got %0d",
                                 want.right, frame_out.right_out));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        frame_out.ready <= 1'b0;
      end else begin
        frame_out.ready <= 1'b1;
        if (idle_on && !calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    if ((frame_in.valid && frame_in.ready) || (frame_out.valid && frame_out.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int n;
    rst = 1'b1;
    frame_in.valid = 1'b0;
    frame_in.left_in = '0;
    frame_in.right_in = '0;
    frame_out.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.data = '0;
    frame_held = 1'b0;
    idle_on = 1'b1;
    calm = 1'b0;
    send_gap = 0;
    quiet_cycles = 0;
    err_count = 0;
    fx_on = 0;
    reverb_on = 0;
    left_lag = 0;
    right_lag = 0;
    fb_coef = COEF_RESET;
    comb_level = LEVEL_RESET;
    comb_len = LENGTH_RESET;
    foreach (mono_ring[i]) mono_ring[i] = '0;
    foreach (comb_line[i]) comb_line[i] = '0;
    ring_wr = 0;
    lp_left_acc = 0;
    lp_right_acc = 0;
    comb_pos = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Frames pass through untouched while the effect is off after reset.
    push_frame(-65536, 65534);
    push_frame(65534, -65536);
    push_frame(0, -1);
    drain();

    set_fx(1, 0, 0, 64, 0, 32767, 1);
    push_frame(32767, 32767);
    push_frame(32768, 32768);
    push_frame(-32768, -32769);
    push_frame(65534, 65534);
    push_frame(-65536, -65536);
    drain();

    // Out-of-range delays and feedback saturate; a zero comb length acts as one.
    set_fx(1, 1, 127, 65, 65535, 32767, 0);
    push_frame(65534, 65534);
    push_frame(-65536, 65534);
    push_frame(12345, -23456);
    push_frame(-1, 1);
    drain();

    set_fx(1, 1, 3, 5, 19412, 32767, 1023);
    repeat (6) push_frame(65534, 32767);
    drain();

    // Shrinking the comb length leaves the position beyond the new length.
    set_fx(1, 1, 3, 5, 19412, 32767, 4);
    push_frame(-65536, -65536);
    push_frame(-32768, -32768);
    push_frame(65534, 65534);
    push_frame(1000, -1000);
    drain();

    set_fx(1, 0, 2, 1, 16384, 4915, 512);
    push_frame(30000, -30000);
    push_frame(-20000, 20000);
    drain();

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      if (RANDOM_FRAMES - sent <= CALM_FRAMES) begin
        calm = 1'b1;
        n = RANDOM_FRAMES - sent;
      end else begin
        n = $urandom_range(40, 200);
        if (n > RANDOM_FRAMES - sent - CALM_FRAMES) n = RANDOM_FRAMES - sent - CALM_FRAMES;
      end
      idle_on = $urandom_range(0, 3) != 0;
      set_fx($urandom_range(0, 6) != 0, $urandom_range(0, 4) > 1,
             edgy(0, MAX_DELAY, 127), edgy(0, MAX_DELAY, 127),
             edgy(0, 32768, 65535), edgy(0, 32767, 32767),
             $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : edgy(1, 1023, 0));
      repeat (n) push_frame(rand_sample(), rand_sample());
      sent += n;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_frames.size()));
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
